// ===== rtl/core/qdcm_pkg.sv =====
// shared types and constants for the queue delay congestion monitor
`timescale 1ns / 1ps
package qdcm_pkg;
    localparam int CFG_IDX_BITS = 2;
    localparam int FRAC_BITS    = 12;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BUFFER_SIZE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_SIZE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIX_PERCENT = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ERR_PERCENT = 2'd3;
    localparam logic CMD_ARRIVAL   = 1'b0;
    localparam logic CMD_DEPARTURE = 1'b1;
endpackage

// ===== rtl/core/queue_delay_congestion_monitor.sv =====
// top level of the queue delay congestion monitor
`timescale 1ns / 1ps
// Receiver-side congestion monitor. One item is handled at a time. A departure
// or a dropped arrival goes straight from the input state to the output state. An
// admitted arrival reads the oldest delay from the window memory, then runs a
// deviation quotient (only when the deviation alert fires) and the window
// average through one shared bit-serial divider. A finished result waits in its
// own output register, so a stalled receiver holds back the input only once the
// next item is done as well. The delay window lives in a synchronous memory; its
// entries reset to zero through per-entry valid bits, so no clearing pass is
// needed.
module queue_delay_congestion_monitor #(
    parameter int WINDOW_MAX = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [qdcm_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [11:0]                   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [TIME_BITS-1:0]          s_arrival_time,
    input  logic [TIME_BITS-1:0]          s_sent_time,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_dropped,
    output logic                          m_alert_valid,
    output logic signed [15:0]            m_alert_value,
    output logic [10:0]                   m_occupancy
);
    import qdcm_pkg::*;

    localparam int PTR_BITS  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FILL_BITS = $clog2(WINDOW_MAX + 1);
    localparam int SUM_BITS  = TIME_BITS + FILL_BITS;
    localparam int PROD_BITS = TIME_BITS + FRAC_BITS + 1;
    localparam int NUM_BITS  = (SUM_BITS > TIME_BITS + FRAC_BITS) ? SUM_BITS
                                                                  : TIME_BITS + FRAC_BITS;
    localparam int DEN_BITS  = TIME_BITS;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_PUSH, ST_DEV, ST_DEV_WAIT, ST_AVG, ST_AVG_WAIT, ST_OUT
    } state_t;

    // configuration registers
    logic [9:0]  buffer_size_reg;
    logic [4:0]  window_size_reg;
    logic [11:0] fix_percent_reg;
    logic [11:0] err_percent_reg;

    // state
    state_t                 state_reg;
    logic [10:0]            count_reg;
    logic [PTR_BITS-1:0]    head_reg;
    logic [FILL_BITS-1:0]   fill_reg;
    logic [SUM_BITS-1:0]    total_reg;
    logic [TIME_BITS-1:0]   avg_reg;
    logic [TIME_BITS-1:0]   prev_reg;
    logic [WINDOW_MAX-1:0]  wvalid_reg;
    logic [TIME_BITS-1:0]   ring_mem [WINDOW_MAX];
    logic [TIME_BITS-1:0]   ring_rd_reg;
    logic                   rd_valid_reg;

    // item registers
    logic [TIME_BITS-1:0]   now_reg;
    logic [TIME_BITS-1:0]   delay_reg;
    logic [TIME_BITS-1:0]   old_avg_reg;
    logic                   pending_reg;

    // result being built
    logic                   res_dropped_reg;
    logic                   res_alert_reg;
    logic [15:0]            res_value_reg;
    logic [10:0]            res_count_reg;

    // result registers
    logic                   out_valid_reg;
    logic                   out_dropped_reg;
    logic                   out_alert_reg;
    logic [15:0]            out_value_reg;
    logic [10:0]            out_count_reg;
    logic                   out_free;

    // divider
    logic                   div_start;
    logic [NUM_BITS-1:0]    div_numer;
    logic [DEN_BITS-1:0]    div_denom;
    logic                   div_done;
    logic [NUM_BITS-1:0]    div_quot;

    qdcm_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(DEN_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .numer(div_numer),
        .denom(div_denom), .done(div_done), .quot(div_quot)
    );

    // effective window
    logic [FILL_BITS:0] eff_win;
    always_comb begin
        if (window_size_reg == 5'd0) eff_win = (FILL_BITS+1)'(1);
        else if (32'(window_size_reg) > WINDOW_MAX) eff_win = (FILL_BITS+1)'(WINDOW_MAX);
        else eff_win = (FILL_BITS+1)'(window_size_reg);
    end

    logic                 evict;
    logic [PTR_BITS-1:0]  oldest_idx;
    logic [PTR_BITS-1:0]  head_next;
    logic [TIME_BITS-1:0] oldest_val;
    always_comb begin
        evict = ({1'b0, fill_reg} >= eff_win) && (fill_reg != '0);
        if (32'(head_reg) >= 32'(fill_reg)) begin
            oldest_idx = PTR_BITS'(32'(head_reg) - 32'(fill_reg));
        end else begin
            oldest_idx = PTR_BITS'(32'(head_reg) + WINDOW_MAX - 32'(fill_reg));
        end
        head_next  = (32'(head_reg) == WINDOW_MAX - 1) ? '0 : head_reg + 1'b1;
        oldest_val = rd_valid_reg ? ring_rd_reg : '0;
    end

    // deviation, slow-arrival and occupancy quantities from the stored delay, previous average and count
    logic [TIME_BITS-1:0] dev_abs;
    logic [PROD_BITS-1:0] dev_scaled;
    logic [PROD_BITS-1:0] err_scaled;
    logic                 dev_ok;
    logic                 dev_alert;
    logic [TIME_BITS+FRAC_BITS+1:0] slow_lhs;
    logic [TIME_BITS+FRAC_BITS+1:0] slow_rhs;
    logic                 slow_alert;
    logic [11:0]          dbl_count;
    logic [12:0]          quad_count;
    logic [11:0]          triple_buf;
    logic                 occ_half;
    logic                 occ_high;
    always_comb begin
        dev_abs    = (delay_reg > old_avg_reg) ? delay_reg - old_avg_reg
                                               : old_avg_reg - delay_reg;
        dev_scaled = {1'b0, dev_abs, {FRAC_BITS{1'b0}}};
        err_scaled = PROD_BITS'(err_percent_reg) * PROD_BITS'(old_avg_reg);
        dev_ok     = (delay_reg != '0) && (old_avg_reg != '0);
        dev_alert  = dev_scaled > err_scaled;
        slow_lhs   = {2'b0, prev_reg, {FRAC_BITS{1'b0}}}
                   + (TIME_BITS+FRAC_BITS+2)'(delay_reg) * (TIME_BITS+FRAC_BITS+2)'(err_percent_reg);
        slow_rhs   = {2'b0, now_reg, {FRAC_BITS{1'b0}}};
        slow_alert = slow_lhs <= slow_rhs;
        dbl_count  = {count_reg, 1'b0};
        quad_count = {count_reg, 2'b0};
        triple_buf = 12'(buffer_size_reg) + {1'b0, buffer_size_reg, 1'b0};
        occ_half   = dbl_count >= 12'(buffer_size_reg);
        occ_high   = quad_count >= 13'(triple_buf);
    end

    always_comb begin
        div_start = 1'b0;
        div_numer = NUM_BITS'({dev_abs, {FRAC_BITS{1'b0}}});
        div_denom = old_avg_reg;
        if (state_reg == ST_DEV) begin
            div_start = dev_alert;
        end else if (state_reg == ST_AVG) begin
            div_start = (fill_reg != '0);
            div_numer = NUM_BITS'(total_reg);
            div_denom = DEN_BITS'(fill_reg);
        end
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || m_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_size_reg <= 10'd200;
            window_size_reg <= 5'd16;
            fix_percent_reg <= 12'd410;
            err_percent_reg <= 12'd205;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BUFFER_SIZE: buffer_size_reg <= cfg_data[9:0];
                CFG_WINDOW_SIZE: window_size_reg <= cfg_data[4:0];
                CFG_FIX_PERCENT: fix_percent_reg <= cfg_data;
                CFG_ERR_PERCENT: err_percent_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // window memory, synchronous read
    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) ring_rd_reg <= ring_mem[oldest_idx];
        if (state_reg == ST_PUSH) ring_mem[head_reg] <= delay_reg;
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            total_reg     <= '0;
            avg_reg       <= '0;
            prev_reg      <= '0;
            wvalid_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            pending_reg   <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        now_reg         <= s_arrival_time;
                        delay_reg       <= s_arrival_time - s_sent_time;
                        old_avg_reg     <= avg_reg;
                        res_alert_reg   <= 1'b0;
                        res_value_reg   <= '0;
                        if (s_command == CMD_DEPARTURE) begin
                            if (count_reg != '0) count_reg <= count_reg - 1'b1;
                            res_dropped_reg <= 1'b0;
                            res_count_reg   <= (count_reg != '0) ? count_reg - 1'b1 : count_reg;
                            state_reg       <= ST_OUT;
                        end else if (count_reg > 11'(buffer_size_reg)) begin
                            res_dropped_reg <= 1'b1;
                            res_count_reg   <= count_reg;
                            state_reg       <= ST_OUT;
                        end else begin
                            res_dropped_reg <= 1'b0;
                            count_reg       <= count_reg + 1'b1;
                            state_reg       <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    rd_valid_reg <= wvalid_reg[oldest_idx];
                    state_reg    <= ST_PUSH;
                end
                ST_PUSH: begin
                    // drop the oldest if full, add the new delay
                    if (evict) begin
                        total_reg <= total_reg - SUM_BITS'(oldest_val) + SUM_BITS'(delay_reg);
                    end else begin
                        total_reg <= total_reg + SUM_BITS'(delay_reg);
                        fill_reg  <= fill_reg + 1'b1;
                    end
                    wvalid_reg[head_reg] <= 1'b1;
                    head_reg      <= head_next;
                    res_count_reg <= count_reg;
                    state_reg     <= ST_DEV;
                end
                ST_DEV: begin
                    if (occ_half) begin
                        res_alert_reg <= 1'b1;
                        res_value_reg <= occ_high ? {3'b0, fix_percent_reg, 1'b0}
                                                  : {4'b0, fix_percent_reg};
                        pending_reg   <= 1'b0;
                        state_reg     <= ST_AVG;
                    end else if (dev_ok && dev_alert) begin
                        res_alert_reg <= 1'b1;
                        pending_reg   <= 1'b1;
                        state_reg     <= ST_DEV_WAIT;
                    end else begin
                        pending_reg <= 1'b0;
                        state_reg   <= ST_AVG;
                        if (dev_ok && prev_reg != '0 && slow_alert) begin
                            res_alert_reg <= 1'b1;
                            res_value_reg <= 16'd0 - {4'b0, fix_percent_reg};
                        end
                    end
                end
                ST_DEV_WAIT: begin
                    if (div_done) begin
                        res_value_reg <= (div_quot > NUM_BITS'(32767)) ? 16'h7FFF
                                                                      : div_quot[15:0];
                        state_reg <= ST_AVG;
                    end
                end
                ST_AVG: begin
                    prev_reg <= now_reg;
                    if (fill_reg == '0) begin
                        avg_reg   <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_AVG_WAIT;
                    end
                end
                ST_AVG_WAIT: begin
                    if (div_done) begin
                        avg_reg   <= div_quot[TIME_BITS-1:0];
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // output register, loaded once the previous result has left
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            out_valid_reg   <= 1'b1;
            out_dropped_reg <= res_dropped_reg;
            out_alert_reg   <= res_alert_reg;
            out_value_reg   <= res_value_reg;
            out_count_reg   <= res_count_reg;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_dropped     = out_dropped_reg;
    assign m_alert_valid = out_alert_reg;
    assign m_alert_value = out_value_reg;
    assign m_occupancy   = out_count_reg;

    // checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fill_reg) <= WINDOW_MAX) else $error("window fill above capacity");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("input taken while busy");
    a_drop_no_alert: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_dropped_reg) |-> !out_alert_reg)
        else $error("alert on dropped arrival");
    a_pending_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DEV_WAIT) |-> pending_reg) else $error("divider wait without start");
endmodule

// ===== rtl/core/qdcm_divider.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module qdcm_divider #(
    parameter int NUM_BITS = 48,
    parameter int DEN_BITS = 36
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_BITS-1:0] numer,
    input  logic [DEN_BITS-1:0] denom,
    output logic                done,
    output logic [NUM_BITS-1:0] quot
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] quot_reg;
    logic [DEN_BITS:0]   rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   shifted;

    // shift in next numerator bit and trial subtract
    always_comb begin
        shifted = {rem_reg[DEN_BITS-1:0], quot_reg[NUM_BITS-1]};
        trial   = shifted - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !start && (cnt_reg == CNT_BITS'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(NUM_BITS);
                quot_reg <= numer;
                rem_reg  <= '0;
                den_reg  <= denom;
            end else if (busy_reg) begin
                if (!trial[DEN_BITS]) begin
                    rem_reg  <= trial;
                    quot_reg <= {quot_reg[NUM_BITS-2:0], 1'b1};
                end else begin
                    rem_reg  <= shifted;
                    quot_reg <= {quot_reg[NUM_BITS-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule

// ===== tb/tb_queue_delay_congestion_monitor.sv =====
// self-checking testbench for the queue delay congestion monitor
`timescale 1ns / 1ps
module tb_queue_delay_congestion_monitor;
    import qdcm_pkg::*;

    localparam int WIN_DEPTH   = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 120;

    typedef struct {
        bit               dropped;
        bit               alert_valid;
        logic signed [15:0] alert_value;
        logic [10:0]      occupancy;
    } verdict_t;

    // predicts one verdict per accepted transfer and checks results in order
    class occupancy_scoreboard;
        bit [9:0]  buf_limit;
        bit [4:0]  win_len;
        bit [11:0] fix_frac;
        bit [11:0] err_frac;
        bit [10:0] occ;
        bit [31:0] delays [WIN_DEPTH];
        int        head;
        int        fill;
        bit [63:0] sum;
        bit [31:0] mean;
        bit [31:0] last_arrival;
        verdict_t  owed [$];

        function new();
            buf_limit = 200; win_len = 16; fix_frac = 410; err_frac = 205;
            occ = 0; head = 0; fill = 0; sum = 0; mean = 0; last_arrival = 0;
            foreach (delays[i]) delays[i] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [11:0] data);
            case (idx)
                CFG_BUFFER_SIZE: buf_limit = data[9:0];
                CFG_WINDOW_SIZE: win_len = data[4:0];
                CFG_FIX_PERCENT: fix_frac = data;
                CFG_ERR_PERCENT: err_frac = data;
                default: ;
            endcase
        endfunction

        function void note_input(bit cmd, bit [31:0] now_t, bit [31:0] sent_t);
            verdict_t  v;
            bit [31:0] delay;
            bit [31:0] prev_mean;
            bit [63:0] dev;
            bit [63:0] quo;
            int        eff;
            v = '{0, 0, 0, 0};
            if (cmd == CMD_DEPARTURE) begin
                if (occ > 0) occ = occ - 1;
            end else if (occ > buf_limit) begin
                v.dropped = 1;
            end else begin
                delay = now_t - sent_t;
                prev_mean = mean;
                occ = occ + 1;
                // slide the delay window, one removal at most
                eff = (win_len == 0) ? 1 : (win_len > WIN_DEPTH) ? WIN_DEPTH : win_len;
                if (fill >= eff && fill > 0) begin
                    sum = sum - delays[(head + WIN_DEPTH - fill) % WIN_DEPTH];
                    fill--;
                end
                delays[head] = delay;
                head = (head + 1) % WIN_DEPTH;
                fill++;
                sum = sum + delay;
                // alert priority: occupancy, deviation, slow arrivals
                if (2 * 64'(occ) >= 64'(buf_limit)) begin
                    v.alert_valid = 1;
                    v.alert_value = (4 * 64'(occ) < 3 * 64'(buf_limit)) ?
                                    16'(fix_frac) : 16'(2 * 64'(fix_frac));
                end else if (delay != 0 && prev_mean != 0) begin
                    dev = (delay > prev_mean) ? 64'(delay - prev_mean) : 64'(prev_mean - delay);
                    if (dev * 4096 > 64'(err_frac) * 64'(prev_mean)) begin
                        quo = (dev * 4096) / 64'(prev_mean);
                        v.alert_valid = 1;
                        v.alert_value = (quo > 32767) ? 16'sd32767 : 16'(quo);
                    end else if (last_arrival != 0) begin
                        if (64'(last_arrival) * 4096 + 64'(delay) * 64'(err_frac)
                                <= 64'(now_t) * 4096) begin
                            v.alert_valid = 1;
                            v.alert_value = 16'(-int'(fix_frac));
                        end
                    end
                end
                mean = (fill != 0) ? 32'(sum / 64'(fill)) : 0;
                last_arrival = now_t;
            end
            v.occupancy = occ;
            owed.push_back(v);
        endfunction

        function string check(verdict_t got);
            verdict_t exp_v;
            string    why;
            if (owed.size() == 0) return "result with no expectation waiting";
            exp_v = owed.pop_front();
            why = "";
            if (got.dropped != exp_v.dropped)
                why = {why, $sformatf(" dropped %0d/%0d", got.dropped, exp_v.dropped)};
            if (got.alert_valid != exp_v.alert_valid)
                why = {why, $sformatf(" alert_valid %0d/%0d", got.alert_valid,
                                      exp_v.alert_valid)};
            if (got.alert_value !== exp_v.alert_value)
                why = {why, $sformatf(" alert_value %0d/%0d", got.alert_value,
                                      exp_v.alert_value)};
            if (got.occupancy !== exp_v.occupancy)
                why = {why, $sformatf(" occupancy %0d/%0d", got.occupancy,
                                      exp_v.occupancy)};
            return why;
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [11:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_command;
    logic [31:0] s_arrival_time;
    logic [31:0] s_sent_time;
    logic        m_valid;
    logic        m_ready;
    logic        m_dropped;
    logic        m_alert_valid;
    logic signed [15:0] m_alert_value;
    logic [10:0] m_occupancy;

    occupancy_scoreboard sb;
    int        errors;
    int        cycles;
    bit        quiet;
    int        hold_asks;
    int        hold_seen;
    int        hold_left;
    int        stall_left;
    bit [31:0] clock_ticks;
    bit [31:0] base_delay;

    queue_delay_congestion_monitor u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_arrival_time (s_arrival_time),
        .s_sent_time    (s_sent_time),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dropped      (m_dropped),
        .m_alert_valid  (m_alert_valid),
        .m_alert_value  (m_alert_value),
        .m_occupancy    (m_occupancy)
    );

    // clock
    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report(string why);
        $display("mismatch at cycle %0d:%s", cycles, why);
        errors++;
    endtask

    // result side ready with random stall bursts and requested long holds
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_left <= 300;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (quiet) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if ($urandom_range(4) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // outputs are stable mid-cycle; a transfer seen here completes at the next edge
    always @(negedge aclk) begin
        verdict_t got;
        string    why;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_dropped, m_alert_valid, m_alert_value, m_occupancy};
            why = sb.check(got);
            if (why != "") report(why);
        end
    end

    task automatic send_item(bit cmd, bit [31:0] now_t, bit [31:0] sent_t);
        s_valid        <= 1'b1;
        s_command      <= cmd;
        s_arrival_time <= now_t;
        s_sent_time    <= sent_t;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        sb.note_input(cmd, now_t, sent_t);
        if (!quiet && $urandom_range(3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // stop offering and let every owed result come back
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [11:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        sb.set_reg(idx, data);
    endtask

    task automatic configure(bit [11:0] buf_v, bit [11:0] win_v, bit [11:0] fix_v,
                             bit [11:0] err_v);
        write_reg(CFG_BUFFER_SIZE, buf_v);
        write_reg(CFG_WINDOW_SIZE, win_v);
        write_reg(CFG_FIX_PERCENT, fix_v);
        write_reg(CFG_ERR_PERCENT, err_v);
        cfg_valid <= 1'b0;
    endtask

    // mostly a steady clock with drifting delays, some zero and wild timestamps
    task automatic random_items(int count, int arrive_pct, int hold_at, int pause_at);
        bit [31:0] now_t;
        bit [31:0] sent_t;
        int        pick;
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) hold_asks++;
            if (i == pause_at) drain();
            pick = $urandom_range(99);
            if ($urandom_range(99) >= arrive_pct) begin
                send_item(CMD_DEPARTURE, $urandom, $urandom);
            end else if (pick < 70) begin
                clock_ticks += $urandom_range(0, 3000);
                if ($urandom_range(9) == 0) base_delay = $urandom_range(1, 20000);
                now_t  = clock_ticks;
                sent_t = now_t - (base_delay + $urandom_range(0, 200));
                send_item(CMD_ARRIVAL, now_t, sent_t);
            end else if (pick < 80) begin
                clock_ticks += $urandom_range(0, 50);
                send_item(CMD_ARRIVAL, clock_ticks, clock_ticks);
            end else begin
                send_item(CMD_ARRIVAL, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        sb = new();
        errors = 0; cycles = 0; quiet = 0;
        hold_asks = 0; hold_seen = 0; hold_left = 0; stall_left = 0;
        clock_ticks = 32'd1000; base_delay = 32'd1000;
        aresetn = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        s_valid = 1'b0; s_command = 1'b0; s_arrival_time = '0; s_sent_time = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty departure, extreme and wrapping timestamps, alerts
        send_item(CMD_DEPARTURE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_ARRIVAL, 32'd0, 32'd0);
        send_item(CMD_ARRIVAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_ARRIVAL, 32'd100, 32'd0);
        send_item(CMD_ARRIVAL, 32'd200, 32'd100);
        send_item(CMD_ARRIVAL, 32'd300, 32'd200);
        send_item(CMD_ARRIVAL, 32'd310, 32'd10);
        send_item(CMD_ARRIVAL, 32'd320, 32'd300);
        send_item(CMD_ARRIVAL, 32'd5000, 32'd4900);
        send_item(CMD_ARRIVAL, 32'd5001, 32'd4902);
        send_item(CMD_ARRIVAL, 32'd0, 32'hFFFF_FFFF);
        send_item(CMD_ARRIVAL, 32'hFFFF_FFFF, 32'd0);
        send_item(CMD_ARRIVAL, 32'h8000_0000, 32'h8000_0001);
        send_item(CMD_ARRIVAL, 32'h8000_1000, 32'h8000_0F00);
        send_item(CMD_DEPARTURE, 32'd0, 32'd0);
        send_item(CMD_DEPARTURE, 32'h5555_5555, 32'hAAAA_AAAA);
        send_item(CMD_ARRIVAL, 32'hAAAA_AAAA, 32'h5555_5555);
        drain();

        // zero buffer and window, full-scale fix, zero tolerance
        configure(12'd0, 12'd0, 12'd4095, 12'd0);
        random_items(40, 60, -1, -1);
        drain();
        // largest buffer, oversized window; receiver holds off for a while
        configure(12'd1023, 12'd31, 12'd1, 12'd4095);
        random_items(80, 85, 20, -1);
        drain();
        // buffer now below the count, window shrunk below its fill
        configure(12'd6, 12'd3, 12'd2048, 12'd410);
        random_items(80, 50, -1, 40);
        drain();
        configure(12'd40, 12'd16, 12'd410, 12'd205);
        random_items(100, 55, -1, -1);
        drain();
        // last stretch with no idling on either side
        configure(12'd12, 12'd1, 12'd1234, 12'd2730);
        quiet = 1;
        random_items(100, 55, -1, -1);
        drain();

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/qdcm_pkg.sv
rtl/core/qdcm_divider.sv
rtl/core/queue_delay_congestion_monitor.sv
tb/tb_queue_delay_congestion_monitor.sv
